// ===== design/mur_pkg.sv =====
// ----------------------------------------------------------------------------
// mur_pkg
// Types, constants and helper types shared by the 64-bit hash unit.
// ----------------------------------------------------------------------------
package mur_pkg;

	localparam logic [63:0] MUR_MULT  = 64'hc6a4a7935bd1e995;
	localparam int          MUR_SHIFT = 47;

	localparam logic [7:0]  LEN_RESET         = 8'd129;
	localparam int          QUEUE_DEPTH_DEF   = 2;

	// How a word enters the hash.
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_PART = 2'd1,
		CLS_FULL = 2'd2
	} word_cls_t;

	// One classified word, as the front hands it to the back.
	typedef struct packed {
		logic [63:0] data;
		word_cls_t   cls;
		logic        last;
		logic        first;
		logic [7:0]  len;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [63:0] operand;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] result;
	} mul_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAIT,
		ST_AFTER_INIT,
		ST_DISPATCH,
		ST_MIX_SHIFT,
		ST_ABSORB,
		ST_SET_H,
		ST_TAIL,
		ST_FIN_DONE
	} back_state_t;

endpackage

// ===== design/mur_mul.sv =====
// ----------------------------------------------------------------------------
// mur_mul
// Multiplies a 64-bit operand by the hash constant modulo 2^64 with one
// 32x32 multiplier, accumulating the low product and the cross terms in turn.
// ----------------------------------------------------------------------------
module mur_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mur_pkg::mul_req_t req,
	output mur_pkg::mul_rsp_t rsp
);
	import mur_pkg::*;

	localparam logic [31:0] MULT_LO = MUR_MULT[31:0];
	localparam logic [31:0] MULT_HI = MUR_MULT[63:32];

	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] prod;

	// Low product first, then the two cross terms, which only reach the
	// upper half of the result.
	always_comb begin
		case (cnt_q)
			2'd0: begin
				op_a = a_q[31:0];
				op_b = MULT_LO;
			end
			2'd1: begin
				op_a = a_q[31:0];
				op_b = MULT_HI;
			end
			default: begin
				op_a = a_q[63:32];
				op_b = MULT_LO;
			end
		endcase
		prod = {32'd0, op_a} * {32'd0, op_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				if (cnt_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.operand;
		end else if (busy_q) begin
			if (cnt_q == 2'd0) begin
				acc_q <= prod;
			end else begin
				acc_q <= acc_q + {prod[31:0], 32'd0};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule

// ===== design/mur_front.sv =====
// ----------------------------------------------------------------------------
// mur_front
// Accepts words, masks and classifies them, tracks message boundaries and
// holds the message length register.
// ----------------------------------------------------------------------------
module mur_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             length_we,
	input  logic [7:0]       message_length,
	input  logic             accept,
	input  logic [63:0]      data_word,
	input  logic [3:0]       word_bytes,
	input  logic             last,
	output mur_pkg::entry_t  entry
);
	import mur_pkg::*;

	logic [7:0]  len_q;
	logic        in_msg_q;
	logic [3:0]  nsat;
	logic [63:0] masked;

	always_comb begin
		nsat = (word_bytes > 4'd8) ? 4'd8 : word_bytes;
		for (int i = 0; i < 8; i++) begin
			masked[8*i +: 8] = (4'(i) < nsat) ? data_word[8*i +: 8] : 8'd0;
		end
	end

	always_comb begin
		entry.data  = masked;
		entry.last  = last;
		entry.first = !in_msg_q;
		entry.len   = len_q;
		if (nsat == 4'd8) begin
			entry.cls = CLS_FULL;
		end else if (nsat == 4'd0) begin
			entry.cls = CLS_ZERO;
		end else begin
			entry.cls = CLS_PART;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LEN_RESET;
			in_msg_q <= 1'b0;
		end else begin
			if (length_we) begin
				len_q <= message_length;
			end
			if (accept) begin
				in_msg_q <= !last;
			end
		end
	end

endmodule

// ===== design/mur_queue.sv =====
// ----------------------------------------------------------------------------
// mur_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
module mur_queue #(
	parameter int DEPTH = mur_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mur_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output mur_pkg::entry_t rd_entry,
	output logic            empty
);
	import mur_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

	entry_t        mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == DEPTH_CNT);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign rd_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// ===== design/mur_back.sv =====
// ----------------------------------------------------------------------------
// mur_back
// Sequencer that mixes queued words into the running hash through the
// shared multiply unit, finalizes it and holds the result register.
// ----------------------------------------------------------------------------
module mur_back (
	input  logic              clk,
	input  logic              arst_n,
	input  mur_pkg::entry_t   q_entry,
	input  logic              q_empty,
	output logic              q_pop,
	output mur_pkg::mul_req_t mul_req,
	input  mur_pkg::mul_rsp_t mul_rsp,
	output logic [63:0]       hash_value,
	output logic              empty,
	input  logic              pop
);
	import mur_pkg::*;

	back_state_t state_q, state_d;
	back_state_t ret_q, ret_d;

	logic [63:0] h_q;
	logic [63:0] word_q;
	word_cls_t   cls_q;
	logic        last_q;
	logic        out_valid_q;
	logic [63:0] out_hash_q;

	logic        load_item;
	logic        load_h;
	logic [63:0] h_d;
	logic        load_out;
	logic [63:0] res;
	logic [63:0] res_fold;

	assign res      = mul_rsp.result;
	assign res_fold = res ^ (res >> MUR_SHIFT);

	always_comb begin
		state_d         = state_q;
		ret_d           = ret_q;
		q_pop           = 1'b0;
		load_item       = 1'b0;
		load_h          = 1'b0;
		h_d             = res;
		load_out        = 1'b0;
		mul_req.start   = 1'b0;
		mul_req.operand = res;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					load_item = 1'b1;
					if (q_entry.first) begin
						mul_req.start   = 1'b1;
						mul_req.operand = {56'd0, q_entry.len};
						ret_d           = ST_AFTER_INIT;
						state_d         = ST_WAIT;
					end else begin
						state_d = ST_DISPATCH;
					end
				end
			end
			ST_WAIT: begin
				if (mul_rsp.done) begin
					state_d = ret_q;
				end
			end
			ST_AFTER_INIT: begin
				load_h  = 1'b1;
				state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (cls_q)
					CLS_FULL: begin
						mul_req.start   = 1'b1;
						mul_req.operand = word_q;
						ret_d           = ST_MIX_SHIFT;
						state_d         = ST_WAIT;
					end
					CLS_PART: begin
						mul_req.start   = 1'b1;
						mul_req.operand = h_q ^ word_q;
						ret_d           = ST_SET_H;
						state_d         = ST_WAIT;
					end
					default: begin
						state_d = ST_TAIL;
					end
				endcase
			end
			ST_MIX_SHIFT: begin
				mul_req.start   = 1'b1;
				mul_req.operand = res_fold;
				ret_d           = ST_ABSORB;
				state_d         = ST_WAIT;
			end
			ST_ABSORB: begin
				mul_req.start   = 1'b1;
				mul_req.operand = h_q ^ res;
				ret_d           = ST_SET_H;
				state_d         = ST_WAIT;
			end
			ST_SET_H: begin
				load_h  = 1'b1;
				state_d = ST_TAIL;
			end
			ST_TAIL: begin
				if (last_q) begin
					mul_req.start   = 1'b1;
					mul_req.operand = h_q ^ (h_q >> MUR_SHIFT);
					ret_d           = ST_FIN_DONE;
					state_d         = ST_WAIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FIN_DONE: begin
				// The result register must be free before the hash leaves.
				if (!out_valid_q) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			word_q <= q_entry.data;
			cls_q  <= q_entry.cls;
			last_q <= q_entry.last;
		end
		if (load_h) begin
			h_q <= h_d;
		end
		if (load_out) begin
			out_hash_q <= res_fold;
		end
	end

	assign hash_value = out_hash_q;
	assign empty      = !out_valid_q;

endmodule

// ===== design/murmur64a_hash_unit.sv =====
// ----------------------------------------------------------------------------
// murmur64a_hash_unit
// 64-bit MurmurHash64A, seed zero, over little-endian message words.
// ----------------------------------------------------------------------------
// Words are pushed with their valid byte count and a last mark; one hash
// comes out for each message, on its last word. The front masks and
// classifies each word and places it in a short queue, so pushes continue
// while the back works, until the queue is full. The back runs every step
// through one shared multiply-by-constant unit built around a single 32x32
// multiplier, and the products of a word depend on one another. A full
// word is multiplied, folded, multiplied again, mixed into the hash and
// multiplied once more; a partial word is mixed into the hash and
// multiplied; an empty word needs no product. The first word of a message
// first seeds the hash from the length and the last word adds finalization.
// The length register is sampled when a message's first word is pushed.
// ----------------------------------------------------------------------------
module murmur64a_hash_unit #(
	parameter int QUEUE_DEPTH = mur_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        length_we,
	input  logic [7:0]  message_length,
	input  logic        push,
	output logic        full,
	input  logic [63:0] data_word,
	input  logic [3:0]  word_bytes,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash_value
);
	import mur_pkg::*;

	entry_t   wr_entry;
	entry_t   rd_entry;
	logic     q_empty;
	logic     q_pop;
	logic     accept;
	mul_req_t mul_req;
	mul_rsp_t mul_rsp;

	assign accept = push && !full;

	mur_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.length_we      (length_we),
		.message_length (message_length),
		.accept         (accept),
		.data_word      (data_word),
		.word_bytes     (word_bytes),
		.last           (last),
		.entry          (wr_entry)
	);

	mur_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (full),
		.pop      (q_pop),
		.rd_entry (rd_entry),
		.empty    (q_empty)
	);

	mur_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	mur_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_entry    (rd_entry),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.mul_req    (mul_req),
		.mul_rsp    (mul_rsp),
		.hash_value (hash_value),
		.empty      (empty),
		.pop        (pop)
	);

endmodule
